[hw/rtl/rtm_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Reinhard tone mapper package
// Shared widths, word types, constants and the build function for the
// gamma knee table used by the tone mapping pipeline.
// ----------------------------------------------------------------------------
package rtm_pkg;

    // Default pipeline parameters.
    localparam int RTM_FRAC_BITS        = 16;
    localparam int RTM_GAMMA_INDEX_BITS = 12;
    localparam int RTM_GAMMA_INDEX_MAX  = 16;

    // Fixed field and datapath widths.
    localparam int RTM_LINEAR_W = 32;
    localparam int RTM_GAIN_W   = 24;
    localparam int RTM_PROD_W   = RTM_LINEAR_W + RTM_GAIN_W;
    localparam int RTM_DEN_W    = RTM_PROD_W + 1;
    localparam int RTM_BYTE_W   = 8;

    // Output levels: the gamma curve yields one of 256 byte codes.
    localparam int RTM_LEVEL_BITS = 8;
    localparam int RTM_LEVELS     = 1 << RTM_LEVEL_BITS;

    localparam logic [RTM_GAIN_W-1:0] RTM_GAIN_ONE     = RTM_GAIN_W'(32'h0001_0000);
    localparam logic [RTM_DEN_W-1:0]  RTM_DEN_ONE      = RTM_DEN_W'(64'h1_0000_0000);
    localparam logic [RTM_BYTE_W-1:0] RTM_ALPHA_OPAQUE = 8'hFF;

    // Input word: one HDR pixel, unsigned Q16.16 per channel.
    typedef struct packed {
        logic [RTM_LINEAR_W-1:0] red_linear;
        logic [RTM_LINEAR_W-1:0] green_linear;
        logic [RTM_LINEAR_W-1:0] blue_linear;
    } rtm_hdr_word_t;

    // Output word: gamma encoded RGB bytes plus alpha.
    typedef struct packed {
        logic [RTM_BYTE_W-1:0] red_byte;
        logic [RTM_BYTE_W-1:0] green_byte;
        logic [RTM_BYTE_W-1:0] blue_byte;
        logic [RTM_BYTE_W-1:0] alpha_byte;
    } rtm_ldr_word_t;

    // Knee table: entry n is the smallest gamma index that maps to byte n.
    typedef logic [RTM_GAMMA_INDEX_MAX-1:0] rtm_knee_tab_t [RTM_LEVELS];

    // Integer power on wide operands, evaluated at elaboration.
    function automatic logic [191:0] rtm_pow(input logic [191:0] base, input int expo);
        logic [191:0] acc;
        acc = 192'd1;
        for (int i = 0; i < expo; i++) begin
            acc = acc * base;
        end
        return acc;
    endfunction

    // Byte n is reached once ((2n-1)/510)^11 <= (k/M)^5 with M the largest index.
    // Each knee is found by a bisection over the index range.
    function automatic rtm_knee_tab_t rtm_build_knees(input int idx_bits);
        rtm_knee_tab_t tab;
        logic [191:0]  lhs;
        logic [191:0]  rhs;
        logic [191:0]  mmax5;
        logic [191:0]  top510;
        int            mmax;
        int            lo;
        int            hi;
        int            mid;
        mmax   = (1 << idx_bits) - 1;
        mmax5  = rtm_pow(192'(mmax), 5);
        top510 = rtm_pow(192'd510, 11);
        tab[0] = '0;
        for (int n = 1; n < RTM_LEVELS; n++) begin
            lhs = rtm_pow(192'(2 * n - 1), 11) * mmax5;
            lo  = 0;
            hi  = mmax;
            while (lo < hi) begin
                mid = (lo + hi) >> 1;
                rhs = rtm_pow(192'(mid), 5) * top510;
                if (lhs <= rhs) begin
                    hi = mid;
                end
                else begin
                    lo = mid + 1;
                end
            end
            tab[n] = RTM_GAMMA_INDEX_MAX'(lo);
        end
        return tab;
    endfunction

endpackage

[hw/rtl/hdr_reinhard_tone_map.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HDR Reinhard tone mapper
// Global Reinhard tone mapping with gamma 1/2.2 encoding, one pixel a clock while not stalled.
// ----------------------------------------------------------------------------
// The block takes one pixel word per clock while not stalled and returns one
// RGBA byte word per pixel, in order. Between input accept and output valid
// the exposure product is registered at the accepting edge, then come one
// divider stage per fraction bit of the Reinhard quotient, eight bisection
// stages for the gamma curve and the output register. The pipeline moves as
// a whole and halts only while its last stage and the output register both
// hold a word the sink has not taken. The exposure gain must be written only
// while the block is empty.
module hdr_reinhard_tone_map #(
    parameter int FRAC_BITS        = rtm_pkg::RTM_FRAC_BITS,
    parameter int GAMMA_INDEX_BITS = rtm_pkg::RTM_GAMMA_INDEX_BITS
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            hdr_valid,
    output logic                            hdr_ready,
    input  rtm_pkg::rtm_hdr_word_t          hdr_word,
    output logic                            ldr_valid,
    input  logic                            ldr_ready,
    output rtm_pkg::rtm_ldr_word_t          ldr_word,
    input  logic                            exposure_we,
    input  logic [rtm_pkg::RTM_GAIN_W-1:0]  exposure_wdata
);
    import rtm_pkg::*;

    localparam int PIPE_DEPTH = 1 + FRAC_BITS + RTM_LEVEL_BITS;
    localparam int CHANNELS   = 3;

    logic [RTM_GAIN_W-1:0]       gain_reg;
    logic [RTM_GAIN_W-1:0]       gain_eff;
    logic                        valid_reg [PIPE_DEPTH];
    logic                        last_valid;
    logic                        stall;
    logic                        pipe_ce;
    logic                        out_load;
    logic                        ldr_valid_reg;
    logic                        ldr_valid_next;
    rtm_ldr_word_t               ldr_word_reg;
    logic [RTM_LINEAR_W-1:0]     lin       [CHANNELS];
    logic [RTM_PROD_W-1:0]       prod_reg  [CHANNELS];
    logic [FRAC_BITS-1:0]        quot      [CHANNELS];
    logic [GAMMA_INDEX_BITS-1:0] gidx      [CHANNELS];
    logic [RTM_LEVEL_BITS-1:0]   level     [CHANNELS];

    // Exposure register; a zero gain acts as unity.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg <= RTM_GAIN_ONE;
        end
        else if (exposure_we)
        begin
            gain_reg <= exposure_wdata;
        end
    end

    assign gain_eff = (gain_reg == '0) ? RTM_GAIN_ONE : gain_reg;

    // Flow control: the pipeline halts only when its last word cannot move on.
    assign last_valid = valid_reg[PIPE_DEPTH-1];
    assign stall      = last_valid && ldr_valid_reg && !ldr_ready;
    assign pipe_ce    = !stall;
    assign out_load   = last_valid && pipe_ce;
    assign hdr_ready  = pipe_ce;

    // Valid bits travel alongside the data stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < PIPE_DEPTH; i++)
            begin
                valid_reg[i] <= 1'b0;
            end
        end
        else if (pipe_ce)
        begin
            valid_reg[0] <= hdr_valid;
            for (int i = 1; i < PIPE_DEPTH; i++)
            begin
                valid_reg[i] <= valid_reg[i-1];
            end
        end
    end

    assign lin[0] = hdr_word.red_linear;
    assign lin[1] = hdr_word.green_linear;
    assign lin[2] = hdr_word.blue_linear;

    for (genvar c = 0; c < CHANNELS; c++) begin : g_chan
        // Exposure multiply: Q16.16 times Q8.16 gives Q24.32.
        always_ff @(posedge clk)
        begin
            if (pipe_ce)
            begin
                prod_reg[c] <= RTM_PROD_W'(RTM_PROD_W'(lin[c]) * RTM_PROD_W'(gain_eff));
            end
        end

        rtm_quot_lane #(
            .FRAC_BITS (FRAC_BITS)
        ) u_quot (
            .clk  (clk),
            .ce   (pipe_ce),
            .prod (prod_reg[c]),
            .quot (quot[c])
        );

        // Gamma index: the top index bits of the quotient, or the quotient padded with low zeros when narrower.
        if (FRAC_BITS >= GAMMA_INDEX_BITS) begin : g_idx_narrow
            assign gidx[c] = quot[c][FRAC_BITS-1 -: GAMMA_INDEX_BITS];
        end
        else begin : g_idx_wide
            assign gidx[c] = {quot[c], {(GAMMA_INDEX_BITS - FRAC_BITS){1'b0}}};
        end

        rtm_gamma_lut #(
            .GAMMA_INDEX_BITS (GAMMA_INDEX_BITS)
        ) u_gamma (
            .clk   (clk),
            .ce    (pipe_ce),
            .index (gidx[c]),
            .level (level[c])
        );
    end

    // Output register parts the pipeline from the sink.
    always_comb
    begin
        ldr_valid_next = ldr_valid_reg;
        if (out_load)
        begin
            ldr_valid_next = 1'b1;
        end
        else if (ldr_ready)
        begin
            ldr_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ldr_valid_reg <= 1'b0;
        end
        else
        begin
            ldr_valid_reg <= ldr_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            ldr_word_reg.red_byte   <= level[0];
            ldr_word_reg.green_byte <= level[1];
            ldr_word_reg.blue_byte  <= level[2];
            ldr_word_reg.alpha_byte <= RTM_ALPHA_OPAQUE;
        end
    end

    assign ldr_valid = ldr_valid_reg;
    assign ldr_word  = ldr_word_reg;

endmodule

[hw/rtl/rtm_quot_lane.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Reinhard quotient lane
// Pipelined restoring divider computing floor(v * 2^F / (1 + v)) for one
// channel, one quotient bit per register stage.
// ----------------------------------------------------------------------------
module rtm_quot_lane #(
    parameter int FRAC_BITS = rtm_pkg::RTM_FRAC_BITS
) (
    input  logic                         clk,
    input  logic                         ce,
    input  logic [rtm_pkg::RTM_PROD_W-1:0] prod,
    output logic [FRAC_BITS-1:0]         quot
);
    import rtm_pkg::*;

    // Stage inputs; stage s produces quotient bit FRAC_BITS-1-s.
    logic [RTM_DEN_W-1:0] rem_in [FRAC_BITS];
    logic [RTM_DEN_W-1:0] den_in [FRAC_BITS];
    logic [FRAC_BITS-1:0] q_in   [FRAC_BITS];

    // Stage registers; the last stage keeps only the quotient.
    logic [RTM_DEN_W-1:0] rem_reg [FRAC_BITS-1];
    logic [RTM_DEN_W-1:0] den_reg [FRAC_BITS-1];
    logic [FRAC_BITS-1:0] q_reg   [FRAC_BITS];

    // The remainder starts at v, which is always below the divisor 1 + v.
    assign rem_in[0] = {1'b0, prod};
    assign den_in[0] = {1'b0, prod} + RTM_DEN_ONE;
    assign q_in[0]   = '0;

    for (genvar s = 0; s < FRAC_BITS; s++) begin : g_stage
        logic [RTM_DEN_W:0]   shifted;
        logic [RTM_DEN_W:0]   diff;
        logic                 fits;
        logic [RTM_DEN_W-1:0] rem_next;
        logic [FRAC_BITS-1:0] q_next;

        if (s > 0) begin : g_link
            assign rem_in[s] = rem_reg[s-1];
            assign den_in[s] = den_reg[s-1];
            assign q_in[s]   = q_reg[s-1];
        end

        // One shift, compare and subtract step.
        assign shifted  = {rem_in[s], 1'b0};
        assign diff     = shifted - {1'b0, den_in[s]};
        assign fits     = shifted >= {1'b0, den_in[s]};
        assign rem_next = fits ? diff[RTM_DEN_W-1:0] : shifted[RTM_DEN_W-1:0];
        assign q_next   = {q_in[s][FRAC_BITS-2:0], fits};

        always_ff @(posedge clk)
        begin
            if (ce)
            begin
                q_reg[s] <= q_next;
            end
        end

        if (s < FRAC_BITS - 1) begin : g_carry
            always_ff @(posedge clk)
            begin
                if (ce)
                begin
                    rem_reg[s] <= rem_next;
                    den_reg[s] <= den_in[s];
                end
            end
        end
    end

    assign quot = q_reg[FRAC_BITS-1];

endmodule

[hw/rtl/rtm_gamma_lut.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gamma curve lookup
// Pipelined bisection over the 255 knees of the gamma 1/2.2 curve, one
// output bit per register stage, yielding the encoded byte for an index.
// ----------------------------------------------------------------------------
module rtm_gamma_lut #(
    parameter int GAMMA_INDEX_BITS = rtm_pkg::RTM_GAMMA_INDEX_BITS
) (
    input  logic                              clk,
    input  logic                              ce,
    input  logic [GAMMA_INDEX_BITS-1:0]       index,
    output logic [rtm_pkg::RTM_LEVEL_BITS-1:0] level
);
    import rtm_pkg::*;

    // Knee table built at elaboration for this index width.
    localparam rtm_knee_tab_t KNEE = rtm_build_knees(GAMMA_INDEX_BITS);

    logic [RTM_LEVEL_BITS-1:0]   cnt_in  [RTM_LEVEL_BITS];
    logic [GAMMA_INDEX_BITS-1:0] idx_in  [RTM_LEVEL_BITS];
    logic [RTM_LEVEL_BITS-1:0]   cnt_reg [RTM_LEVEL_BITS];
    logic [GAMMA_INDEX_BITS-1:0] idx_reg [RTM_LEVEL_BITS-1];

    assign cnt_in[0] = '0;
    assign idx_in[0] = index;

    for (genvar s = 0; s < RTM_LEVEL_BITS; s++) begin : g_stage
        localparam logic [RTM_LEVEL_BITS-1:0] STEP =
            RTM_LEVEL_BITS'(1 << (RTM_LEVEL_BITS - 1 - s));
        logic [RTM_LEVEL_BITS-1:0] cand;
        logic                      take;

        if (s > 0) begin : g_link
            assign cnt_in[s] = cnt_reg[s-1];
            assign idx_in[s] = idx_reg[s-1];
        end

        // Keep the trial bit when its knee does not lie above the index.
        assign cand = cnt_in[s] | STEP;
        assign take = KNEE[cand] <= RTM_GAMMA_INDEX_MAX'(idx_in[s]);

        always_ff @(posedge clk)
        begin
            if (ce)
            begin
                cnt_reg[s] <= take ? cand : cnt_in[s];
            end
        end

        if (s < RTM_LEVEL_BITS - 1) begin : g_carry
            always_ff @(posedge clk)
            begin
                if (ce)
                begin
                    idx_reg[s] <= idx_in[s];
                end
            end
        end
    end

    assign level = cnt_reg[RTM_LEVEL_BITS-1];

endmodule

[hw/rtl/rtm_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Reinhard tone mapper port checker
// Concurrent assertions on the top level ports, bound to the tone mapper.
// ----------------------------------------------------------------------------
module rtm_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           hdr_valid,
    input logic                           hdr_ready,
    input rtm_pkg::rtm_hdr_word_t         hdr_word,
    input logic                           ldr_valid,
    input logic                           ldr_ready,
    input rtm_pkg::rtm_ldr_word_t         ldr_word
);
    import rtm_pkg::*;

    // Every delivered word is fully opaque.
    a_alpha_opaque: assert property (@(posedge clk) disable iff (!rst_n)
        ldr_valid |-> ldr_word.alpha_byte == RTM_ALPHA_OPAQUE)
        else $error("alpha byte is not opaque");

    // A word the sink has not taken stays put.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        ldr_valid && !ldr_ready |=> ldr_valid && $stable(ldr_word))
        else $error("output word changed while stalled");

    // A pixel word the block has not taken stays offered and unchanged.
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        hdr_valid && !hdr_ready |=> hdr_valid && $stable(hdr_word))
        else $error("input word changed while waiting");

    // With room at the output the pipeline never refuses a word.
    a_ready_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        !ldr_valid || ldr_ready |-> hdr_ready)
        else $error("input stalled although the output can drain");

    // Reset empties the output.
    a_reset_empty: assert property (@(posedge clk)
        !rst_n |-> !ldr_valid)
        else $error("output valid during reset");

endmodule

bind hdr_reinhard_tone_map rtm_checker u_rtm_checker (.*);
